/* rtl/bcu_pkg.sv */
package bcu_pkg;

  localparam int LIMB_WIDTH     = 32;
  localparam int COEF_WIDTH     = 2 * LIMB_WIDTH;
  localparam int DIV_STEP_BITS  = 4;
  localparam int DIV_CYCLES     = COEF_WIDTH / DIV_STEP_BITS;
  localparam int DIV_CNT_WIDTH  = $clog2(DIV_CYCLES);

endpackage

/* rtl/bcu_mul.sv */
module bcu_mul #(
  parameter int ARG_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic [bcu_pkg::LIMB_WIDTH-1:0]          a,
  input  logic [ARG_WIDTH-1:0]                    b,
  output logic [bcu_pkg::LIMB_WIDTH+ARG_WIDTH-1:0] p
);

  always_ff @(posedge clk) begin
    p <= {{ARG_WIDTH{1'b0}}, a} * {{bcu_pkg::LIMB_WIDTH{1'b0}}, b};
  end

endmodule

/* rtl/bcu_div.sv */
module bcu_div #(
  parameter int ARG_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ARG_WIDTH-1:0]           rem_init,
  input  logic [bcu_pkg::COEF_WIDTH-1:0] dividend,
  input  logic [ARG_WIDTH-1:0]           divisor,
  output logic                           done,
  output logic [bcu_pkg::COEF_WIDTH-1:0] quotient
);

  logic                                  busy;
  logic [bcu_pkg::DIV_CNT_WIDTH-1:0]     cnt;
  logic [ARG_WIDTH-1:0]                  rem;
  logic [bcu_pkg::COEF_WIDTH-1:0]        quo;
  logic [ARG_WIDTH-1:0]                  rem_next;
  logic [bcu_pkg::COEF_WIDTH-1:0]        quo_next;

  always_comb begin
    logic [ARG_WIDTH:0] trial;
    logic [ARG_WIDTH:0] diff;
    logic               qbit;
    rem_next = rem;
    quo_next = quo;
    for (int j = 0; j < bcu_pkg::DIV_STEP_BITS; j++) begin
      trial = {rem_next, quo_next[bcu_pkg::COEF_WIDTH-1]};
      diff  = trial - {1'b0, divisor};
      qbit  = (trial >= {1'b0, divisor});
      rem_next = qbit ? diff[ARG_WIDTH-1:0] : trial[ARG_WIDTH-1:0];
      quo_next = {quo_next[bcu_pkg::COEF_WIDTH-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= bcu_pkg::DIV_CNT_WIDTH'(bcu_pkg::DIV_CYCLES - 1);
      end else if (busy) begin
        cnt <= cnt - bcu_pkg::DIV_CNT_WIDTH'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= rem_init;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

/* rtl/binomial_coefficient_unit_core.sv */
// Binomial coefficient unit: returns C(n,k) for each transaction on the item channel.
// The item channel carries n_value and k_value; a transaction completes when item_valid
// is high and item_stall is low. Only the low ARG_WIDTH bits of each argument are used.
// The result channel carries coefficient and overflow under result_valid/result_stall.
// One item is worked on at a time; item_stall stays high from acceptance until the
// result transaction completes.
// When k is zero or k exceeds n, the item goes straight to the result. Otherwise each
// step i = 1 .. k makes two passes through the shared 32-bit by ARG_WIDTH multiplier,
// joins the partial products and tests for overflow, then runs the shared divider,
// which retires 4 quotient bits per cycle, until the step with i equal to k is done.
// An overflowing partial value ends the item with all ones and overflow set.
// While result_stall is high the result is held and no new item is accepted.
// Reset returns the sequencer to idle and discards any item in progress.
module binomial_coefficient_unit_core #(
  parameter int ARG_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] n_value,
  input  logic [31:0] k_value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [63:0] coefficient,
  output logic        overflow
);

  localparam int CW = bcu_pkg::COEF_WIDTH;
  localparam int LW = bcu_pkg::LIMB_WIDTH;
  localparam int PW = LW + ARG_WIDTH;
  localparam int SW = CW + ARG_WIDTH;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MUL_LO  = 6'b000010,
    ST_MUL_HI  = 6'b000100,
    ST_COMBINE = 6'b001000,
    ST_DIV     = 6'b010000,
    ST_DONE    = 6'b100000
  } state_t;

  state_t               state;
  logic [ARG_WIDTH-1:0] k;
  logic [ARG_WIDTH-1:0] i;
  logic [ARG_WIDTH-1:0] m;
  logic [CW-1:0]        r;
  logic [PW-1:0]        plo;
  logic [CW-1:0]        coef;
  logic                 ovf;

  logic [LW-1:0]        mul_a;
  logic [PW-1:0]        mul_p;
  logic [SW-1:0]        sum;
  logic                 sum_ovf;
  logic                 div_start;
  logic                 div_done;
  logic [CW-1:0]        div_q;
  logic [ARG_WIDTH-1:0] n_arg;
  logic [ARG_WIDTH-1:0] k_arg;

  assign n_arg   = n_value[ARG_WIDTH-1:0];
  assign k_arg   = k_value[ARG_WIDTH-1:0];
  assign mul_a   = (state == ST_MUL_HI) ? r[CW-1:LW] : r[LW-1:0];
  assign sum     = {mul_p, {LW{1'b0}}} + {{LW{1'b0}}, plo};
  assign sum_ovf = (sum[SW-1:CW] >= i);
  assign div_start = (state == ST_COMBINE) && !sum_ovf;

  bcu_mul #(.ARG_WIDTH(ARG_WIDTH)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (m),
    .p   (mul_p)
  );

  bcu_div #(.ARG_WIDTH(ARG_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (sum[SW-1:CW]),
    .dividend (sum[CW-1:0]),
    .divisor  (i),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            state <= ((k_arg > n_arg) || (k_arg == '0)) ? ST_DONE : ST_MUL_LO;
          end
        end
        ST_MUL_LO:  state <= ST_MUL_HI;
        ST_MUL_HI:  state <= ST_COMBINE;
        ST_COMBINE: state <= sum_ovf ? ST_DONE : ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            state <= (i == k) ? ST_DONE : ST_MUL_LO;
          end
        end
        ST_DONE: begin
          if (!result_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        k <= k_arg;
        m <= n_arg;
        i <= ARG_WIDTH'(1);
        r <= CW'(1);
        ovf <= 1'b0;
        coef <= (k_arg > n_arg) ? '0 : CW'(1);
      end
      ST_MUL_HI: begin
        plo <= mul_p;
      end
      ST_COMBINE: begin
        if (sum_ovf) begin
          coef <= '1;
          ovf  <= 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          r    <= div_q;
          coef <= div_q;
          i    <= i + ARG_WIDTH'(1);
          m    <= m - ARG_WIDTH'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign item_stall   = (state != ST_IDLE);
  assign result_valid = (state == ST_DONE);
  assign coefficient  = coef;
  assign overflow     = ovf;

endmodule

/* sim/tb_binomial_coefficient_unit_core.sv */
module tb_binomial_coefficient_unit_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ARG_WIDTH = 32;
  localparam logic [31:0] ARG_MASK = 32'hFFFF_FFFF >> (32 - ARG_WIDTH);
  localparam int PROD_WIDTH = bcu_pkg::COEF_WIDTH + bcu_pkg::LIMB_WIDTH;
  localparam int RANDOM_ITEMS = 1200;
  localparam int QUIET_FROM = 400;
  localparam int QUIET_TO = 600;
  localparam int HOLD_AT_RESULT = 120;
  localparam int HOLD_CYCLES = 2000;
  localparam int IDLE_PERCENT = 9;
  localparam int DRAIN_CYCLES = 50;
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int DIRECTED_COUNT = 22;

  localparam logic [31:0] DIRECTED_N [DIRECTED_COUNT] = '{
    32'd0, 32'd5, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFE, 32'd1, 32'd2,
    32'd10, 32'd52, 32'd67, 32'd67, 32'd68, 32'd68, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
    32'h5555_5555
  };
  localparam logic [31:0] DIRECTED_K [DIRECTED_COUNT] = '{
    32'd0, 32'd0, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1,
    32'd5, 32'd5, 32'd33, 32'd67, 32'd34, 32'd68, 32'd1, 32'd2,
    32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd2, 32'h5555_5555,
    32'hAAAA_AAAA
  };

  typedef struct packed {
    logic [bcu_pkg::COEF_WIDTH-1:0] coefficient;
    logic                           overflow;
  } coef_result_t;

  class coefficient_tracker;
    coef_result_t pending_results[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    function coef_result_t binomial_of(bit [31:0] n, bit [31:0] k);
      coef_result_t res;
      bit [PROD_WIDTH-1:0] product;
      bit [PROD_WIDTH-1:0] quotient;
      bit [bcu_pkg::COEF_WIDTH-1:0] running;
      bit [31:0] factor;
      bit [32:0] step;
      res.coefficient = '0;
      res.overflow = 1'b0;
      if (k > n) begin
        return res;
      end
      running = 1;
      for (step = 33'd1; step <= {1'b0, k}; step++) begin
        factor = n - step[31:0] + 32'd1;
        product = {{bcu_pkg::LIMB_WIDTH{1'b0}}, running} *
                  {{bcu_pkg::COEF_WIDTH{1'b0}}, factor};
        quotient = product / {{bcu_pkg::COEF_WIDTH{1'b0}}, step[31:0]};
        if (quotient[PROD_WIDTH-1:bcu_pkg::COEF_WIDTH] != 0) begin
          res.coefficient = '1;
          res.overflow = 1'b1;
          return res;
        end
        running = quotient[bcu_pkg::COEF_WIDTH-1:0];
      end
      res.coefficient = running;
      return res;
    endfunction

    function void note_item(logic [31:0] n, logic [31:0] k);
      pending_results.push_back(binomial_of(n & ARG_MASK, k & ARG_MASK));
    endfunction

    function void check_result(logic [bcu_pkg::COEF_WIDTH-1:0] coef, logic ovf);
      coef_result_t want;
      if (pending_results.size() == 0) begin
        $error("result transaction with no item outstanding: coefficient %0h, overflow %0b",
               coef, ovf);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (coef !== want.coefficient) begin
        $error("coefficient mismatch: expected %0h, actual %0h", want.coefficient, coef);
        mismatches++;
      end
      if (ovf !== want.overflow) begin
        $error("overflow mismatch: expected %0b, actual %0b", want.overflow, ovf);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [31:0] n_value = '0;
  logic [31:0] k_value = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [bcu_pkg::COEF_WIDTH-1:0] coefficient;
  logic overflow;

  coefficient_tracker tracker = new();
  int items_sent = 0;
  int results_seen = 0;

  binomial_coefficient_unit_core #(
    .ARG_WIDTH(ARG_WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .n_value(n_value),
    .k_value(k_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .coefficient(coefficient),
    .overflow(overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] scaled_random();
    return $urandom >> $urandom_range(0, 31);
  endfunction

  function automatic void pick_item(output logic [31:0] n, output logic [31:0] k);
    int sel;
    int gap;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      n = $urandom_range(0, 67);
      k = $urandom_range(0, n + 2);
    end else if (sel < 50) begin
      n = $urandom;
      k = $urandom;
    end else if (sel < 70) begin
      n = scaled_random();
      k = $urandom_range(0, 40);
    end else if (sel < 85) begin
      n = scaled_random();
      gap = $urandom_range(0, 3);
      k = (n >= gap) ? n - gap : 32'd0;
    end else begin
      n = scaled_random();
      k = n + 32'd1 + $urandom_range(0, 5);
      if (k <= n) begin
        k = 32'hFFFF_FFFF;
      end
    end
  endfunction

  task automatic offer_item(input logic [31:0] n, input logic [31:0] k);
    if (!(items_sent >= QUIET_FROM && items_sent < QUIET_TO)) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    n_value <= n;
    k_value <= k;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    tracker.note_item(n, k);
    items_sent++;
  endtask

  initial begin
    logic [31:0] n;
    logic [31:0] k;
    int idx;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (idx = 0; idx < DIRECTED_COUNT; idx++) begin
      offer_item(DIRECTED_N[idx], DIRECTED_K[idx]);
    end
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      pick_item(n, k);
      offer_item(n, k);
    end
    item_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("tb_binomial_coefficient_unit_core passed");
    end else begin
      $display("tb_binomial_coefficient_unit_core failed");
    end
    $finish;
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (result_valid === 1'b1 && result_stall == 1'b0) begin
        tracker.check_result(coefficient, overflow);
        results_seen++;
      end
      if (!hold_done && results_seen == HOLD_AT_RESULT) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if (results_seen >= QUIET_FROM && results_seen < QUIET_TO) begin
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    wait (rst == 1'b0);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("tb_binomial_coefficient_unit_core failed");
    $finish;
  end

endmodule
